FILE: src/i2c_register_transfer_sequencer_macros.svh
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RTS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sequencer check failed");

// next-cycle implication, sampled on clk, off during rst
`define RTS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sequencer check failed");

`endif

FILE: src/i2c_rts_pkg.sv
package i2c_rts_pkg;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_REQ       = 4'd1,
    PH_ADDRESSED = 4'd2,
    PH_REG_SENT  = 4'd3,
    PH_RESTART   = 4'd4,
    PH_READ_ADDR = 4'd5,
    PH_READING   = 4'd6,
    PH_WRITING   = 4'd7,
    PH_CLOSING   = 4'd8
  } phase_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;

  localparam logic [2:0] EV_START_SENT = 3'd0;
  localparam logic [2:0] EV_TX_SEL     = 3'd1;
  localparam logic [2:0] EV_RX_SEL     = 3'd2;
  localparam logic [2:0] EV_RX_BYTE    = 3'd3;
  localparam logic [2:0] EV_BYTE_DONE  = 3'd4;
  localparam logic [2:0] EV_ACK_FAIL   = 3'd5;

  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_ADDR_W    = 3'd1;
  localparam logic [2:0] CMD_ADDR_R    = 3'd2;
  localparam logic [2:0] CMD_DATA      = 3'd3;
  localparam logic [2:0] CMD_START     = 3'd4;
  localparam logic [2:0] CMD_STOP      = 3'd5;
  localparam logic [2:0] CMD_DATA_STOP = 3'd6;

  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_NOSLAVE = 2'd2;
  localparam logic [1:0] ST_PROTO   = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic       is_read;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [2:0] event_code;
    logic [7:0] rx_data;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic [1:0] ack_action;
    logic       buffer_events_on;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [1:0] status;
  } rsp_t;

endpackage

FILE: src/i2c_register_transfer_sequencer.sv
// The result is registered: rsp_valid rises in the cycle after a request is accepted.
// Throughput: one request per cycle while rsp_ready is high; the result register frees in the cycle it is taken.
// Reset: rst (synchronous, active high) sets phase idle, clears the latched
// transfer fields and drops rsp_valid.
module i2c_register_transfer_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  i2c_rts_pkg::req_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output i2c_rts_pkg::rsp_t  rsp
);

  i2c_rts_pkg::phase_t phase, phase_next;
  logic       read_mode, read_mode_next;
  logic [6:0] target_device, target_device_next;
  logic [7:0] target_register, target_register_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] bytes_dec;
  i2c_rts_pkg::rsp_t res;
  logic       accept;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign bytes_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next           = phase;
    read_mode_next       = read_mode;
    target_device_next   = target_device;
    target_register_next = target_register;
    bytes_left_next      = bytes_left;
    res                  = '0;
    case (req.operation)
      i2c_rts_pkg::OP_START: begin
        if (phase == i2c_rts_pkg::PH_IDLE) begin
          read_mode_next       = req.is_read;
          target_device_next   = req.dev_addr;
          target_register_next = req.reg_addr;
          bytes_left_next      = (req.byte_count == 8'd0) ? 8'd1 : req.byte_count;
          res.command          = i2c_rts_pkg::CMD_START;
          phase_next           = i2c_rts_pkg::PH_REQ;
        end
      end
      i2c_rts_pkg::OP_EVENT: begin
        case (phase)
          i2c_rts_pkg::PH_REQ: begin
            if (req.event_code == i2c_rts_pkg::EV_START_SENT) begin
              res.command = i2c_rts_pkg::CMD_ADDR_W;
              res.tx_byte = {target_device, 1'b0};
              if (read_mode) res.ack_action = i2c_rts_pkg::ACK_ENABLE;
              phase_next = i2c_rts_pkg::PH_ADDRESSED;
            end else if (read_mode) begin
              res.status = i2c_rts_pkg::ST_PROTO;
              phase_next = i2c_rts_pkg::PH_IDLE;
            end
          end
          i2c_rts_pkg::PH_ADDRESSED: begin
            if (req.event_code == i2c_rts_pkg::EV_TX_SEL) begin
              res.command = i2c_rts_pkg::CMD_DATA;
              res.tx_byte = target_register;
              phase_next  = read_mode ? i2c_rts_pkg::PH_REG_SENT : i2c_rts_pkg::PH_WRITING;
            end
          end
          i2c_rts_pkg::PH_REG_SENT: begin
            if (req.event_code == i2c_rts_pkg::EV_BYTE_DONE) begin
              res.command = i2c_rts_pkg::CMD_START;
              phase_next  = i2c_rts_pkg::PH_RESTART;
            end
          end
          i2c_rts_pkg::PH_RESTART: begin
            if (req.event_code == i2c_rts_pkg::EV_START_SENT) begin
              res.command          = i2c_rts_pkg::CMD_ADDR_R;
              res.tx_byte          = {target_device, 1'b1};
              res.buffer_events_on = 1'b1;
              phase_next           = i2c_rts_pkg::PH_READ_ADDR;
            end
          end
          i2c_rts_pkg::PH_READ_ADDR: begin
            if (req.event_code == i2c_rts_pkg::EV_RX_SEL) begin
              if (bytes_left == 8'd1) res.ack_action = i2c_rts_pkg::ACK_DISABLE;
              phase_next = i2c_rts_pkg::PH_READING;
            end
          end
          i2c_rts_pkg::PH_READING: begin
            if (req.event_code == i2c_rts_pkg::EV_RX_BYTE) begin
              res.rx_valid    = 1'b1;
              res.rx_byte     = req.rx_data;
              bytes_left_next = bytes_dec;
              if (bytes_dec == 8'd1) begin
                res.ack_action = i2c_rts_pkg::ACK_DISABLE;
              end else if (bytes_dec == 8'd0) begin
                res.command = i2c_rts_pkg::CMD_STOP;
                res.status  = i2c_rts_pkg::ST_OK;
                phase_next  = i2c_rts_pkg::PH_IDLE;
              end
            end
          end
          i2c_rts_pkg::PH_WRITING: begin
            if (req.event_code == i2c_rts_pkg::EV_BYTE_DONE) begin
              res.tx_byte     = req.write_data;
              bytes_left_next = bytes_dec;
              if (bytes_dec == 8'd0) begin
                res.command = i2c_rts_pkg::CMD_DATA_STOP;
                phase_next  = i2c_rts_pkg::PH_CLOSING;
              end else begin
                res.command = i2c_rts_pkg::CMD_DATA;
              end
            end
          end
          i2c_rts_pkg::PH_CLOSING: begin
            res.status = i2c_rts_pkg::ST_OK;
            phase_next = i2c_rts_pkg::PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      i2c_rts_pkg::OP_ERROR: begin
        if (phase == i2c_rts_pkg::PH_ADDRESSED) begin
          if (req.event_code == i2c_rts_pkg::EV_ACK_FAIL) begin
            res.status = i2c_rts_pkg::ST_NOSLAVE;
            phase_next = i2c_rts_pkg::PH_IDLE;
          end
        end else if (phase != i2c_rts_pkg::PH_IDLE) begin
          res.status = i2c_rts_pkg::ST_PROTO;
          phase_next = i2c_rts_pkg::PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2c_rts_pkg::PH_IDLE;
      read_mode       <= 1'b0;
      target_device   <= 7'd0;
      target_register <= 8'd0;
      bytes_left      <= 8'd0;
      rsp_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        read_mode       <= read_mode_next;
        target_device   <= target_device_next;
        target_register <= target_register_next;
        bytes_left      <= bytes_left_next;
        rsp_valid       <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rsp <= res;
  end

`include "i2c_register_transfer_sequencer_macros.svh"

`RTS_ASSERT_NOW(a_count_live, (phase != i2c_rts_pkg::PH_IDLE && phase != i2c_rts_pkg::PH_CLOSING), (bytes_left != 8'd0))
`RTS_ASSERT_NEXT(a_busy_start_dropped, (accept && req.operation == i2c_rts_pkg::OP_START && phase != i2c_rts_pkg::PH_IDLE), (rsp_valid && rsp.command == i2c_rts_pkg::CMD_NONE))
`RTS_ASSERT_NOW(a_final_idle, (rsp_valid && rsp.status != i2c_rts_pkg::ST_BUSY && $past(accept)), (phase == i2c_rts_pkg::PH_IDLE))

endmodule

FILE: dv/i2c_register_transfer_sequencer_tb.sv
`timescale 1ns / 100ps

module i2c_register_transfer_sequencer_tb;

  class transfer_scoreboard;
    i2c_rts_pkg::rsp_t   expected_q[$];
    i2c_rts_pkg::phase_t phase;
    logic                read_mode;
    logic [6:0]          device;
    logic [7:0]          reg_byte;
    logic [7:0]          remaining;
    int                  errors;

    function new();
      phase     = i2c_rts_pkg::PH_IDLE;
      read_mode = 1'b0;
      device    = '0;
      reg_byte  = '0;
      remaining = '0;
      errors    = 0;
    endfunction

    function void note_request(i2c_rts_pkg::req_t r);
      i2c_rts_pkg::rsp_t o;
      o = '0;
      case (r.operation)
        i2c_rts_pkg::OP_START: begin
          if (phase == i2c_rts_pkg::PH_IDLE) begin
            read_mode = r.is_read;
            device    = r.dev_addr;
            reg_byte  = r.reg_addr;
            remaining = (r.byte_count == 8'd0) ? 8'd1 : r.byte_count;
            o.command = i2c_rts_pkg::CMD_START;
            phase     = i2c_rts_pkg::PH_REQ;
          end
        end
        i2c_rts_pkg::OP_EVENT: begin
          case (phase)
            i2c_rts_pkg::PH_REQ: begin
              if (r.event_code == i2c_rts_pkg::EV_START_SENT) begin
                o.command = i2c_rts_pkg::CMD_ADDR_W;
                o.tx_byte = {device, 1'b0};
                if (read_mode) o.ack_action = i2c_rts_pkg::ACK_ENABLE;
                phase = i2c_rts_pkg::PH_ADDRESSED;
              end else if (read_mode) begin
                o.status = i2c_rts_pkg::ST_PROTO;
                phase    = i2c_rts_pkg::PH_IDLE;
              end
            end
            i2c_rts_pkg::PH_ADDRESSED: begin
              if (r.event_code == i2c_rts_pkg::EV_TX_SEL) begin
                o.command = i2c_rts_pkg::CMD_DATA;
                o.tx_byte = reg_byte;
                phase     = read_mode ? i2c_rts_pkg::PH_REG_SENT : i2c_rts_pkg::PH_WRITING;
              end
            end
            i2c_rts_pkg::PH_REG_SENT: begin
              if (r.event_code == i2c_rts_pkg::EV_BYTE_DONE) begin
                o.command = i2c_rts_pkg::CMD_START;
                phase     = i2c_rts_pkg::PH_RESTART;
              end
            end
            i2c_rts_pkg::PH_RESTART: begin
              if (r.event_code == i2c_rts_pkg::EV_START_SENT) begin
                o.command          = i2c_rts_pkg::CMD_ADDR_R;
                o.tx_byte          = {device, 1'b1};
                o.buffer_events_on = 1'b1;
                phase              = i2c_rts_pkg::PH_READ_ADDR;
              end
            end
            i2c_rts_pkg::PH_READ_ADDR: begin
              if (r.event_code == i2c_rts_pkg::EV_RX_SEL) begin
                if (remaining == 8'd1) o.ack_action = i2c_rts_pkg::ACK_DISABLE;
                phase = i2c_rts_pkg::PH_READING;
              end
            end
            i2c_rts_pkg::PH_READING: begin
              if (r.event_code == i2c_rts_pkg::EV_RX_BYTE) begin
                o.rx_valid = 1'b1;
                o.rx_byte  = r.rx_data;
                remaining  = remaining - 8'd1;
                if (remaining == 8'd1) begin
                  o.ack_action = i2c_rts_pkg::ACK_DISABLE;
                end else if (remaining == 8'd0) begin
                  o.command = i2c_rts_pkg::CMD_STOP;
                  o.status  = i2c_rts_pkg::ST_OK;
                  phase     = i2c_rts_pkg::PH_IDLE;
                end
              end
            end
            i2c_rts_pkg::PH_WRITING: begin
              if (r.event_code == i2c_rts_pkg::EV_BYTE_DONE) begin
                o.tx_byte = r.write_data;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0) begin
                  o.command = i2c_rts_pkg::CMD_DATA_STOP;
                  phase     = i2c_rts_pkg::PH_CLOSING;
                end else begin
                  o.command = i2c_rts_pkg::CMD_DATA;
                end
              end
            end
            i2c_rts_pkg::PH_CLOSING: begin
              o.status = i2c_rts_pkg::ST_OK;
              phase    = i2c_rts_pkg::PH_IDLE;
            end
            default: ;
          endcase
        end
        i2c_rts_pkg::OP_ERROR: begin
          if (phase == i2c_rts_pkg::PH_ADDRESSED) begin
            if (r.event_code == i2c_rts_pkg::EV_ACK_FAIL) begin
              o.status = i2c_rts_pkg::ST_NOSLAVE;
              phase    = i2c_rts_pkg::PH_IDLE;
            end
          end else if (phase != i2c_rts_pkg::PH_IDLE) begin
            o.status = i2c_rts_pkg::ST_PROTO;
            phase    = i2c_rts_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
      expected_q.push_back(o);
    endfunction

    function void report(string name, int want, int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    endfunction

    function void check_result(i2c_rts_pkg::rsp_t got);
      i2c_rts_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.command !== want.command) report("command", want.command, got.command);
      if (got.tx_byte !== want.tx_byte) report("tx_byte", want.tx_byte, got.tx_byte);
      if (got.ack_action !== want.ack_action)
        report("ack_action", want.ack_action, got.ack_action);
      if (got.buffer_events_on !== want.buffer_events_on)
        report("buffer_events_on", want.buffer_events_on, got.buffer_events_on);
      if (got.rx_valid !== want.rx_valid) report("rx_valid", want.rx_valid, got.rx_valid);
      if (got.rx_byte !== want.rx_byte) report("rx_byte", want.rx_byte, got.rx_byte);
      if (got.status !== want.status) report("status", want.status, got.status);
    endfunction
  endclass

  localparam int TARGET_REQUESTS = 750;
  localparam int HOLD_AFTER      = 200;
  localparam int HOLD_CYCLES     = 300;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  logic req_ready;
  logic rsp_valid;
  i2c_rts_pkg::req_t req = '0;
  i2c_rts_pkg::rsp_t rsp;

  transfer_scoreboard sb = new();
  int  results_seen = 0;
  int  sent         = 0;
  bit  calm         = 1'b0;

  always #6 clk = ~clk;

  i2c_register_transfer_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) begin
        sb.check_result(rsp);
        results_seen++;
      end
    end
  end

  function automatic i2c_rts_pkg::req_t mk(logic [1:0] op, logic rd, logic [6:0] dev,
                                           logic [7:0] ra, logic [7:0] cnt, logic [2:0] ev,
                                           logic [7:0] rxd, logic [7:0] wrd);
    i2c_rts_pkg::req_t r;
    r.operation  = op;
    r.is_read    = rd;
    r.dev_addr   = dev;
    r.reg_addr   = ra;
    r.byte_count = cnt;
    r.event_code = ev;
    r.rx_data    = rxd;
    r.write_data = wrd;
    return r;
  endfunction

  // mostly the event the current phase waits for, with random payload
  function automatic i2c_rts_pkg::req_t random_request();
    i2c_rts_pkg::req_t r;
    logic [63:0]       bits;
    bits = {$urandom, $urandom};
    r    = bits[44:0];
    if ($urandom_range(99) < 12) begin
      if (sb.phase == i2c_rts_pkg::PH_IDLE && r.operation == i2c_rts_pkg::OP_START)
        r.operation = i2c_rts_pkg::OP_EVENT;
      if (sb.phase == i2c_rts_pkg::PH_ADDRESSED && $urandom_range(1) == 1) begin
        r.operation  = i2c_rts_pkg::OP_ERROR;
        r.event_code = i2c_rts_pkg::EV_ACK_FAIL;
      end
      return r;
    end
    r.operation = i2c_rts_pkg::OP_EVENT;
    case (sb.phase)
      i2c_rts_pkg::PH_IDLE: begin
        r.operation  = i2c_rts_pkg::OP_START;
        r.byte_count = ($urandom_range(24) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      end
      i2c_rts_pkg::PH_REQ, i2c_rts_pkg::PH_RESTART:
        r.event_code = i2c_rts_pkg::EV_START_SENT;
      i2c_rts_pkg::PH_ADDRESSED:
        r.event_code = i2c_rts_pkg::EV_TX_SEL;
      i2c_rts_pkg::PH_REG_SENT, i2c_rts_pkg::PH_WRITING:
        r.event_code = i2c_rts_pkg::EV_BYTE_DONE;
      i2c_rts_pkg::PH_READ_ADDR:
        r.event_code = i2c_rts_pkg::EV_RX_SEL;
      i2c_rts_pkg::PH_READING:
        r.event_code = i2c_rts_pkg::EV_RX_BYTE;
      default:
        r.event_code = 3'($urandom_range(7));
    endcase
    return r;
  endfunction

  task automatic send_request(input i2c_rts_pkg::req_t r);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent++;
    @(negedge clk);
  endtask

  initial begin : rsp_side
    int  rate;
    bit  held;
    rate = 15;
    held = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      if ($urandom_range(63) == 0) rate = ($urandom_range(1) == 1) ? 0 : 25;
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(99) < rate) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin : req_side
    i2c_rts_pkg::req_t plan[$];
    int                rate;
    rate = 15;
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd1,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_ERROR, 1'b0, 7'h00, 8'h00, 8'd1,
                      i2c_rts_pkg::EV_ACK_FAIL, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_START, 1'b0, 7'h7F, 8'hFF, 8'd2,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_START, 1'b1, 7'h00, 8'h00, 8'd255,
                      i2c_rts_pkg::EV_START_SENT, 8'hFF, 8'hFF));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_TX_SEL, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_BYTE_DONE, 8'hFF, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_BYTE_DONE, 8'h00, 8'hFF));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      3'd7, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_START, 1'b1, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_RX_SEL, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_START, 1'b1, 7'h55, 8'hAA, 8'd2,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_ERROR, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_ACK_FAIL, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_START, 1'b1, 7'h2A, 8'h55, 8'd0,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_TX_SEL, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_ERROR, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_TX_SEL, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_BYTE_DONE, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_RX_SEL, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_EVENT, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_RX_BYTE, 8'hFF, 8'h00));
    plan.push_back(mk(2'd3, 1'b1, 7'h7F, 8'hFF, 8'd255, 3'd6, 8'hFF, 8'hFF));
    plan.push_back(mk(i2c_rts_pkg::OP_START, 1'b0, 7'h01, 8'h80, 8'd1,
                      i2c_rts_pkg::EV_START_SENT, 8'h00, 8'h00));
    plan.push_back(mk(i2c_rts_pkg::OP_ERROR, 1'b0, 7'h00, 8'h00, 8'd0,
                      i2c_rts_pkg::EV_BYTE_DONE, 8'h00, 8'h00));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send_request(plan[i]);

    while (sent < TARGET_REQUESTS) begin
      calm = (sent >= TARGET_REQUESTS - 80);
      if ($urandom_range(63) == 0) rate = ($urandom_range(1) == 1) ? 0 : 25;
      send_request(random_request());
      if (!calm && $urandom_range(99) < rate) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
    end
    req_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("i2c_register_transfer_sequencer regression: pass");
    end else begin
      $display("i2c_register_transfer_sequencer regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("i2c_register_transfer_sequencer regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/i2c_rts_pkg.sv
src/i2c_register_transfer_sequencer.sv
dv/i2c_register_transfer_sequencer_tb.sv
